// ===== hdl/frb_pkg.sv =====
// frb_pkg: shared types and constants of the fragment reassembly buffer.
// Depends on nothing; used by every module in hdl/ except frb_queue.
package frb_pkg;

    localparam int DEF_MAX_FRAGS     = 32;
    localparam int DEF_PAYLOAD_BYTES = 8;
    localparam int CMD_DEPTH         = 2;
    localparam int OUT_DEPTH         = 4;
    localparam int OUT_CNT_W         = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_OVF   = 2'd1;
    localparam logic [1:0] CMD_ASM   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  offset;
        logic        finish;
        logic [3:0]  len;
        logic [63:0] payload;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic [63:0] payload;
        logic [3:0]  len;
        logic        last;
    } t_res;

endpackage

// ===== hdl/fragment_reassembly_buffer.sv =====
// Fragment reassembly buffer: collects fragments of one configured type into
// MAX_FRAGS slots by offset; on an assemble item emits them in offset order, or a
// single not-available result (status 1, last 1) when nothing arrived, offset 0
// or an inner offset is missing, an offset was out of range, or the highest
// fragment lacks finish. The first fragment at an offset is kept; the store is
// cleared by every assembly. Input and results both look like queues: push/full
// and pop/empty. A fragment is taken by the front and queued; the back stores
// a fragment or checks an assembly, then emits the pieces in order as it walks
// the payload memory (one read port, registered read), taking no new command
// and holding its reads while the result queue has no room for them.
// Depends on frb_pkg, frb_queue, frb_front, frb_back.
module fragment_reassembly_buffer #(
    parameter int MAX_FRAGS     = frb_pkg::DEF_MAX_FRAGS,
    parameter int PAYLOAD_BYTES = frb_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // fragment input
    input  logic        push,
    output logic        full,
    input  logic        i_operation,
    input  logic [7:0]  i_frag_type,
    input  logic [7:0]  i_frag_offset,
    input  logic        i_finish,
    input  logic [3:0]  i_payload_length,
    input  logic [63:0] i_payload,
    // results
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic [63:0] o_out_payload,
    output logic [3:0]  o_out_length,
    output logic        o_last
);
    frb_pkg::t_cmd front_cmd, q_cmd;
    frb_pkg::t_res back_res, q_res;
    logic          cmd_push, cmd_pop, cmd_empty, res_push, res_full;
    logic [$clog2(frb_pkg::CMD_DEPTH+1)-1:0] cmd_count;
    logic [frb_pkg::OUT_CNT_W-1:0]           res_count;

    // Front: filter by type, classify, trim payload.
    frb_front #(.MAX_FRAGS(MAX_FRAGS), .PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_push(push), .i_q_full(full),
        .i_operation(i_operation), .i_frag_type(i_frag_type),
        .i_frag_offset(i_frag_offset), .i_finish(i_finish),
        .i_payload_length(i_payload_length), .i_payload(i_payload),
        .o_q_push(cmd_push), .o_cmd(front_cmd)
    );

    // Command queue decouples the front from the back.
    frb_queue #(.WIDTH($bits(frb_pkg::t_cmd)), .DEPTH(frb_pkg::CMD_DEPTH)) u_cmd_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(cmd_push), .i_data(front_cmd), .i_pop(cmd_pop),
        .o_data(q_cmd), .o_full(full), .o_empty(cmd_empty), .o_count(cmd_count)
    );

    // Back: slot store, checks and ordered emission.
    frb_back #(.MAX_FRAGS(MAX_FRAGS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_empty(cmd_empty), .i_cmd(q_cmd), .o_cmd_pop(cmd_pop),
        .i_out_count(res_count), .o_res_push(res_push), .o_res(back_res)
    );

    // Result queue: the oldest result sits on the outputs while empty is low.
    frb_queue #(.WIDTH($bits(frb_pkg::t_res)), .DEPTH(frb_pkg::OUT_DEPTH)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(res_push), .i_data(back_res), .i_pop(pop),
        .o_data(q_res), .o_full(res_full), .o_empty(empty), .o_count(res_count)
    );

    assign o_status      = q_res.status && !(res_full && cmd_count[0] && 1'b0);
    assign o_out_payload = q_res.payload;
    assign o_out_length  = q_res.len;
    assign o_last        = q_res.last;
endmodule

// ===== hdl/frb_queue.sv =====
// frb_queue: small synchronous FIFO with occupancy count.
// Used for the command queue and the result queue; no package dependency.
module frb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== hdl/frb_front.sv =====
// frb_front: holds the wanted-type register, filters and classifies fragments.
// Depends on frb_pkg (t_cmd, command kinds).
module frb_front #(
    parameter int MAX_FRAGS     = frb_pkg::DEF_MAX_FRAGS,
    parameter int PAYLOAD_BYTES = frb_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_push,
    input  logic                i_q_full,
    input  logic                i_operation,
    input  logic [7:0]          i_frag_type,
    input  logic [7:0]          i_frag_offset,
    input  logic                i_finish,
    input  logic [3:0]          i_payload_length,
    input  logic [63:0]         i_payload,
    output logic                o_q_push,
    output frb_pkg::t_cmd       o_cmd
);
    logic [7:0] r_wanted_type;
    logic [3:0] sat_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_type <= '0;
        end else if (i_cfg_we) begin
            r_wanted_type <= i_cfg_wdata;
        end
    end

    // Saturate the length, then clear bytes above it.
    always_comb begin
        sat_len = (i_payload_length > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES)
                                                          : i_payload_length;
        o_cmd.offset = i_frag_offset;
        o_cmd.finish = i_finish;
        o_cmd.len    = sat_len;
        for (int b = 0; b < 8; b++) begin
            o_cmd.payload[b*8 +: 8] = (4'(b) < sat_len) ? i_payload[b*8 +: 8] : 8'h00;
        end
        if (i_operation) begin
            o_cmd.kind = frb_pkg::CMD_ASM;
        end else if (9'(i_frag_offset) >= 9'(MAX_FRAGS)) begin
            o_cmd.kind = frb_pkg::CMD_OVF;
        end else begin
            o_cmd.kind = frb_pkg::CMD_STORE;
        end
        // Drop fragments of other types here.
        o_q_push = i_push && !i_q_full && (i_operation || (i_frag_type == r_wanted_type));
    end
endmodule

// ===== hdl/frb_back.sv =====
// frb_back: slot store, assembly check and ordered walk over the payload memory.
// Depends on frb_pkg (t_cmd, t_res, command kinds, result queue sizing).
module frb_back #(
    parameter int MAX_FRAGS = frb_pkg::DEF_MAX_FRAGS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_empty,
    input  frb_pkg::t_cmd                i_cmd,
    output logic                         o_cmd_pop,
    input  logic [frb_pkg::OUT_CNT_W-1:0] i_out_count,
    output logic                         o_res_push,
    output frb_pkg::t_res                o_res
);
    localparam int SLOT_W = $clog2(MAX_FRAGS);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic [63:0]          r_pay_mem [MAX_FRAGS];
    logic [3:0]           r_len_mem [MAX_FRAGS];
    logic [MAX_FRAGS-1:0] r_valid, n_valid, r_fin, n_fin, mask;
    logic [SLOT_W-1:0]    r_high, n_high, r_top, n_top, r_addr, n_addr, off;
    logic                 r_ovf, n_ovf, r_state, n_state;
    logic                 r_rd_vld, r_rd_last, n_rd_last, rd_en, wr_en, asm_ok;
    logic [63:0]          r_rd_pay;
    logic [3:0]           r_rd_len;

    assign off = i_cmd.offset[SLOT_W-1:0];

    always_comb begin
        for (int i = 0; i < MAX_FRAGS; i++) begin
            mask[i] = (SLOT_W'(i) <= r_high);
        end
        asm_ok = !r_ovf && ((r_valid & mask) == mask) && r_fin[r_high];
    end

    always_comb begin
        n_valid    = r_valid;
        n_fin      = r_fin;
        n_high     = r_high;
        n_ovf      = r_ovf;
        n_state    = r_state;
        n_top      = r_top;
        n_addr     = r_addr;
        n_rd_last  = r_rd_last;
        o_cmd_pop  = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        o_res_push = r_rd_vld;
        o_res      = '{status: 1'b0, payload: r_rd_pay, len: r_rd_len, last: r_rd_last};
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.kind)
                        frb_pkg::CMD_STORE: begin
                            o_cmd_pop = 1'b1;
                            if (!r_valid[off]) begin
                                wr_en        = 1'b1;
                                n_valid[off] = 1'b1;
                                n_fin[off]   = i_cmd.finish;
                                if (off > r_high) begin
                                    n_high = off;
                                end
                            end
                        end
                        frb_pkg::CMD_OVF: begin
                            o_cmd_pop = 1'b1;
                            n_ovf     = 1'b1;
                        end
                        frb_pkg::CMD_ASM: begin
                            // Hold until the last walk read has landed and there is room.
                            if (!r_rd_vld && (i_out_count < frb_pkg::OUT_CNT_W'(frb_pkg::OUT_DEPTH))) begin
                                o_cmd_pop = 1'b1;
                                n_valid   = '0;
                                n_fin     = '0;
                                n_high    = '0;
                                n_ovf     = 1'b0;
                                if (asm_ok) begin
                                    n_state = ST_WALK;
                                    n_top   = r_high;
                                    n_addr  = '0;
                                end else begin
                                    o_res_push = 1'b1;
                                    o_res = '{status: 1'b1, payload: 64'd0, len: 4'd0, last: 1'b1};
                                end
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // Issue a read only if its result is sure to find room.
                if ((5'(i_out_count) + 5'(r_rd_vld)) < 5'(frb_pkg::OUT_DEPTH)) begin
                    rd_en     = 1'b1;
                    n_rd_last = (r_addr == r_top);
                    n_addr    = r_addr + 1'b1;
                    if (r_addr == r_top) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pay_mem[off] <= i_cmd.payload;
            r_len_mem[off] <= i_cmd.len;
        end
        if (rd_en) begin
            r_rd_pay <= r_pay_mem[r_addr];
            r_rd_len <= r_len_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fin     <= '0;
            r_high    <= '0;
            r_ovf     <= 1'b0;
            r_state   <= ST_IDLE;
            r_top     <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_fin     <= n_fin;
            r_high    <= n_high;
            r_ovf     <= n_ovf;
            r_state   <= n_state;
            r_top     <= n_top;
            r_addr    <= n_addr;
            r_rd_vld  <= rd_en;
            r_rd_last <= n_rd_last;
        end
    end
endmodule

// ===== sim/frb_checker.sv =====
`timescale 1ns / 100ps
// frb_checker: watches the config, fragment and result channels of the fragment
// reassembly buffer, predicts every result and compares it. Depends on frb_pkg.
module frb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_operation,
    input  logic [7:0]  i_frag_type,
    input  logic [7:0]  i_frag_offset,
    input  logic        i_finish,
    input  logic [3:0]  i_payload_length,
    input  logic [63:0] i_payload,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_status,
    input  logic [63:0] i_out_payload,
    input  logic [3:0]  i_out_length,
    input  logic        i_last,
    output int          o_pending,
    output int          o_errors
);

    localparam int SLOTS = frb_pkg::DEF_MAX_FRAGS;
    localparam int BYTES = frb_pkg::DEF_PAYLOAD_BYTES;

    bit [7:0]       collect_type;
    bit             have_frag [SLOTS];
    bit             frag_fin  [SLOTS];
    bit [63:0]      frag_data [SLOTS];
    bit [3:0]       frag_len  [SLOTS];
    bit [4:0]       top_offset;
    bit             overflow;
    frb_pkg::t_res  expected_pieces [$];
    int             error_count;

    function automatic void clear_slots();
        for (int i = 0; i < SLOTS; i++) begin
            have_frag[i] = 1'b0;
            frag_fin[i]  = 1'b0;
        end
        top_offset = '0;
        overflow   = 1'b0;
    endfunction

    // Apply one accepted item; queue the pieces an assembly produces.
    function automatic void reassemble(bit op, bit [7:0] ftype, bit [7:0] off, bit fin,
                                       bit [3:0] len, bit [63:0] data);
        bit            complete;
        frb_pkg::t_res piece;
        if (!op) begin
            if (ftype != collect_type)
                return;
            if (off >= SLOTS) begin
                overflow = 1'b1;
                return;
            end
            if (have_frag[off])
                return;
            if (len > BYTES)
                len = BYTES;
            have_frag[off] = 1'b1;
            frag_fin[off]  = fin;
            frag_len[off]  = len;
            frag_data[off] = (len >= 8) ? data : data & ((64'd1 << (len * 8)) - 1);
            if (off[4:0] > top_offset)
                top_offset = off[4:0];
            return;
        end
        complete = !overflow;
        for (int i = 0; i <= top_offset; i++)
            if (!have_frag[i])
                complete = 1'b0;
        if (complete && !frag_fin[top_offset])
            complete = 1'b0;
        if (!complete) begin
            piece = '{status: 1'b1, payload: 64'd0, len: 4'd0, last: 1'b1};
            expected_pieces = {expected_pieces, piece};
        end else begin
            for (int i = 0; i <= top_offset; i++) begin
                piece = '{status: 1'b0, payload: frag_data[i], len: frag_len[i],
                          last: (i == top_offset)};
                expected_pieces = {expected_pieces, piece};
            end
        end
        clear_slots();
    endfunction

    always @(posedge i_clk) begin
        frb_pkg::t_res want;
        if (!i_rst_n) begin
            collect_type = '0;
            clear_slots();
            expected_pieces.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_pieces.size() == 0) begin
                    $display("%0t: unexpected result status=%0b payload=%h len=%0d last=%0b",
                             $time, i_status, i_out_payload, i_out_length, i_last);
                    error_count++;
                end else begin
                    want = expected_pieces.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, i_status);
                        error_count++;
                    end
                    if (i_out_payload !== want.payload) begin
                        $display("%0t: payload expected %h actual %h",
                                 $time, want.payload, i_out_payload);
                        error_count++;
                    end
                    if (i_out_length !== want.len) begin
                        $display("%0t: length expected %0d actual %0d",
                                 $time, want.len, i_out_length);
                        error_count++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, i_last);
                        error_count++;
                    end
                end
            end
            if (i_push && !i_full)
                reassemble(i_operation, i_frag_type, i_frag_offset, i_finish,
                           i_payload_length, i_payload);
            if (i_cfg_we)
                collect_type = i_cfg_wdata;
        end
        o_pending <= expected_pieces.size();
        o_errors  <= error_count;
    end

endmodule

// ===== sim/fragment_reassembly_buffer_test.sv =====
`timescale 1ns / 100ps
// fragment_reassembly_buffer_test: drives fragments and assemble items into the
// buffer in bursts under several collected types while the result side stalls,
// and gives the verdict. Depends on frb_checker and the buffer RTL.
module fragment_reassembly_buffer_test;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    typedef enum int {
        FLAW_NONE, FLAW_GAP, FLAW_NO_ZERO, FLAW_NO_FINISH, FLAW_OVERFLOW
    } t_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic        i_operation = 1'b0;
    logic [7:0]  i_frag_type = '0;
    logic [7:0]  i_frag_offset = '0;
    logic        i_finish = 1'b0;
    logic [3:0]  i_payload_length = '0;
    logic [63:0] i_payload = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_status;
    logic [63:0] o_out_payload;
    logic [3:0]  o_out_length;
    logic        o_last;

    int       pending;
    int       errors;
    bit [7:0] collect_type;
    int       useful_items;
    int       burst_left;
    int       idle_cycles = 0;

    fragment_reassembly_buffer dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .push, .full, .i_operation, .i_frag_type, .i_frag_offset, .i_finish,
        .i_payload_length, .i_payload,
        .empty, .pop, .o_status, .o_out_payload, .o_out_length, .o_last
    );

    frb_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_push(push), .i_full(full), .i_operation, .i_frag_type, .i_frag_offset,
        .i_finish, .i_payload_length, .i_payload,
        .i_empty(empty), .i_pop(pop), .i_status(o_status), .i_out_payload(o_out_payload),
        .i_out_length(o_out_length), .i_last(o_last),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: switch between free-running, light and heavy stall patterns.
    int stall_mode = 0;
    int mode_cycles = 0;
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(20, 120);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            default: pop <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Abort when no transaction of any kind completes for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Push one item; insert a random gap whenever the current burst runs out.
    task automatic send(bit op, bit [7:0] ftype, bit [7:0] off, bit fin,
                        bit [3:0] len, bit [63:0] data);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        push             <= 1'b1;
        i_operation      <= op;
        i_frag_type      <= ftype;
        i_frag_offset    <= off;
        i_finish         <= fin;
        i_payload_length <= len;
        i_payload        <= data;
        do @(posedge i_clk); while (full);
        if (op || ftype == collect_type)
            useful_items++;
    endtask

    function automatic bit [63:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    task automatic store(bit [7:0] off, bit fin, bit [3:0] len);
        send(1'b0, collect_type, off, fin, len, rand_data());
    endtask

    // Assemble with the unused fields randomized.
    task automatic assemble();
        send(1'b1, $urandom, $urandom, $urandom, $urandom, rand_data());
    endtask

    // Hold the sender until every result is out and the back end has drained.
    task automatic write_type(bit [7:0] value);
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        collect_type = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One fragmented packet of count pieces, shuffled, with noise and duplicates,
    // broken on purpose according to flaw, then an assemble.
    task automatic send_packet(int count, t_flaw flaw);
        bit [7:0] order [$];
        int       skip;
        int       pick;
        bit [7:0] tmp;
        for (int i = 0; i < count; i++)
            order = {order, 8'(i)};
        for (int i = count - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        skip = -1;
        if (flaw == FLAW_NO_ZERO)
            skip = 0;
        else if (flaw == FLAW_GAP && count >= 3)
            skip = $urandom_range(1, count - 2);
        foreach (order[i]) begin
            if ($urandom_range(0, 4) == 0)
                send(1'b0, collect_type + $urandom_range(1, 255), $urandom, $urandom,
                     $urandom, rand_data());
            if (order[i] == skip)
                continue;
            store(order[i],
                  (order[i] == count - 1) ? (flaw != FLAW_NO_FINISH)
                                          : ($urandom_range(0, 5) == 0),
                  $urandom_range(0, 15));
            if ($urandom_range(0, 6) == 0)
                store(order[$urandom_range(0, i)], $urandom, $urandom_range(0, 15));
            if (flaw == FLAW_OVERFLOW && i == 0)
                store($urandom_range(32, 255), 1'b1, $urandom_range(0, 15));
        end
        assemble();
    endtask

    task automatic random_phase(bit [7:0] ftype, int quota);
        int    roll;
        t_flaw flaw;
        write_type(ftype);
        useful_items = 0;
        while (useful_items < quota) begin
            roll = $urandom_range(0, 19);
            flaw = (roll < 13) ? FLAW_NONE : t_flaw'(roll % 5);
            if (roll == 19)
                assemble();
            else
                send_packet($urandom_range(1, 6), flaw);
        end
    endtask

    initial begin
        burst_left  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset type.
        write_type(8'h00);
        assemble();                                    // nothing collected
        send(1'b0, 8'h00, 8'd0, 1'b1, 4'd15, '1);      // long length, all ones
        assemble();
        store(8'd0, 1'b1, 4'd0);                       // empty payload
        store(8'd255, 1'b1, 4'd8);                     // out of range offset
        assemble();
        store(8'd0, 1'b1, 4'd8);                       // finish on inner piece
        store(8'd1, 1'b0, 4'd3);
        assemble();
        store(8'd0, 1'b0, 4'd1);                       // hole in the offsets
        store(8'd2, 1'b1, 4'd2);
        assemble();
        send(1'b0, 8'h00, 8'd0, 1'b1, 4'd3, 64'h0123_4567_89ab_cdef);
        send(1'b0, 8'h00, 8'd0, 1'b0, 4'd8, '1);       // duplicate keeps first
        assemble();
        store(8'd1, 1'b1, 4'd4);                       // offset 0 missing
        assemble();
        send(1'b0, 8'hff, 8'd0, 1'b1, 4'd8, '1);       // other type ignored
        assemble();

        // Random part: a full store once, then several collected types.
        write_type(8'hff);
        send_packet(32, FLAW_NONE);
        random_phase(8'hff, 45);
        random_phase(8'h5a, 45);
        random_phase($urandom, 45);
        random_phase(8'h00, 45);

        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/frb_pkg.sv
hdl/frb_queue.sv
hdl/frb_front.sv
hdl/frb_back.sv
hdl/fragment_reassembly_buffer.sv
sim/frb_checker.sv
sim/fragment_reassembly_buffer_test.sv
